/* design/nfa_tt_pkg.sv */
`timescale 1ns / 1ps

package nfa_tt_pkg;

	localparam int STATE_COUNT  = 16;
	localparam int SYMBOL_COUNT = 16;
	localparam int ROW_COUNT    = STATE_COUNT * SYMBOL_COUNT;
	localparam int ROW_W        = STATE_COUNT;
	localparam int ROW_AW       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int CNT_W        = $clog2(STATE_COUNT * ROW_COUNT + 1);
	localparam int MULTI_W      = $clog2(ROW_COUNT + 1);

	localparam int KIND_W   = 2;
	localparam int FIELD_W  = 4;
	localparam int SET_W    = 16;
	localparam int TOTAL_W  = 13;

	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [ROW_AW-1:0] row_addr_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] target;
		logic               in_range;
	} req_t;

	typedef struct packed {
		logic changed;
		row_t after;
		row_t row_out;
		logic inc;
		logic dec;
		logic many_up;
		logic many_down;
	} upd_t;

endpackage

/* design/nfa_tt_row_mem.sv */
`timescale 1ns / 1ps

module nfa_tt_row_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  nfa_tt_pkg::row_addr_t rd_addr,
	output nfa_tt_pkg::row_t      rd_data,
	input  logic                  wr_en,
	input  nfa_tt_pkg::row_addr_t wr_addr,
	input  nfa_tt_pkg::row_t      wr_data
);
	import nfa_tt_pkg::*;

	row_t                 mem [ROW_COUNT];
	logic [ROW_COUNT-1:0] row_valid_q;
	row_t                 data_q;
	logic                 data_valid_q;

	// A row that was never written since reset reads as an empty row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q  <= '0;
			data_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				data_valid_q <= row_valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	assign rd_data = data_valid_q ? data_q : '0;

endmodule

/* design/nfa_tt_update.sv */
`timescale 1ns / 1ps

module nfa_tt_update (
	input  nfa_tt_pkg::req_t req,
	input  nfa_tt_pkg::row_t prior,
	output nfa_tt_pkg::upd_t upd
);
	import nfa_tt_pkg::*;

	row_t bit_v;
	row_t after;
	logic tgt_ok;
	logic present;
	logic modify;
	logic do_add;
	logic do_rem;
	logic was_many;
	logic is_many;

	always_comb begin
		tgt_ok   = int'(req.target) < STATE_COUNT;
		bit_v    = row_t'(1) << req.target;
		present  = |(prior & bit_v);
		modify   = req.in_range && tgt_ok;
		do_add   = modify && (req.kind == KIND_ADD) && !present;
		do_rem   = modify && (req.kind == KIND_REMOVE) && present;
		after    = do_add ? (prior | bit_v) : (do_rem ? (prior & ~bit_v) : prior);
		was_many = |(prior & (prior - row_t'(1)));
		is_many  = |(after & (after - row_t'(1)));

		upd.changed   = do_add || do_rem;
		upd.after     = after;
		upd.row_out   = req.in_range ? after : '0;
		upd.inc       = do_add;
		upd.dec       = do_rem;
		upd.many_up   = is_many && !was_many;
		upd.many_down = was_many && !is_many;
	end

endmodule

/* design/nfa_transition_table.sv */
`timescale 1ns / 1ps

// Transition table of a nondeterministic automaton with one target bitset per
// (source state, symbol) row, held in a synchronous memory that is empty after
// reset. Each transaction adds a triple, removes one or looks up a row (any other
// kind only looks up), and gives exactly one result. Its row is read from the
// memory port, then updated and, if changed, written back, so in_stall is high
// in the cycle after each accepted transaction and no new one is taken while one
// is in the update stage. While a result waits on out_stall, one more transaction
// is taken and read, and in_stall then stays high until that result is accepted.
module nfa_transition_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  source_state,
	input  logic [3:0]  input_symbol,
	input  logic [3:0]  target_state,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        changed,
	output logic [15:0] target_set,
	output logic [12:0] transition_total,
	output logic        deterministic
);
	import nfa_tt_pkg::*;

	logic               accept;
	logic               advance;
	logic               busy_s1;
	req_t               req_s1;
	row_addr_t          addr_s1;
	row_addr_t          rd_addr;
	logic               in_range;
	row_t               rd_data;
	upd_t               upd;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic [MULTI_W-1:0] multi_q;
	logic [MULTI_W-1:0] multi_next;
	logic               out_valid_q;
	logic               changed_q;
	logic [SET_W-1:0]   set_q;
	logic [TOTAL_W-1:0] total_q;
	logic               det_q;
	logic [ROW_W+SET_W-1:0]     set_ext;
	logic [CNT_W+TOTAL_W-1:0]   total_ext;

	assign in_stall = busy_s1;
	assign accept   = in_valid && !busy_s1;
	assign advance  = busy_s1 && !(out_valid_q && out_stall);

	assign in_range = (int'(source_state) < STATE_COUNT) && (int'(input_symbol) < SYMBOL_COUNT);
	assign rd_addr  = ROW_AW'(int'(source_state) * SYMBOL_COUNT + int'(input_symbol));

	nfa_tt_row_mem u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (advance && upd.changed),
		.wr_addr (addr_s1),
		.wr_data (upd.after)
	);

	nfa_tt_update u_update (
		.req   (req_s1),
		.prior (rd_data),
		.upd   (upd)
	);

	assign count_next = count_q + CNT_W'(upd.inc) - CNT_W'(upd.dec);
	assign multi_next = multi_q + MULTI_W'(upd.many_up) - MULTI_W'(upd.many_down);
	assign set_ext    = {{SET_W{1'b0}}, upd.row_out};
	assign total_ext  = {{TOTAL_W{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			multi_q     <= '0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (advance) begin
				busy_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next;
				multi_q     <= multi_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.kind     <= kind;
			req_s1.target   <= target_state;
			req_s1.in_range <= in_range;
			addr_s1         <= rd_addr;
		end
		if (advance) begin
			changed_q <= upd.changed;
			set_q     <= set_ext[SET_W-1:0];
			total_q   <= total_ext[TOTAL_W-1:0];
			det_q     <= (multi_next == '0);
		end
	end

	assign out_valid        = out_valid_q;
	assign changed          = changed_q;
	assign target_set       = set_q;
	assign transition_total = total_q;
	assign deterministic    = det_q;

`ifndef SYNTHESIS
	a_result_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_s1))
		else $error("Result appeared without an item in the update stage.");

	a_multi_rows_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) >= 2 * int'(multi_q))
		else $error("More multi-target rows than the triple count allows.");

	a_add_counts_up: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && upd.changed && (req_s1.kind == KIND_ADD))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("Inserted triple did not raise the triple count.");

	a_lookup_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_s1.kind == KIND_LOOKUP)) |-> !upd.changed)
		else $error("Lookup changed the table.");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import nfa_tt_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic               changed;
		logic [SET_W-1:0]   target_set;
		logic [TOTAL_W-1:0] transition_total;
		logic               deterministic;
	} table_reply_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [KIND_W-1:0] kind;
	logic [FIELD_W-1:0] source_state;
	logic [FIELD_W-1:0] input_symbol;
	logic [FIELD_W-1:0] target_state;
	logic out_valid;
	logic out_stall;
	logic changed;
	logic [SET_W-1:0] target_set;
	logic [TOTAL_W-1:0] transition_total;
	logic deterministic;

	logic [SET_W-1:0] row_table [ROW_COUNT];
	int triple_total;
	int crowded_rows;
	table_reply_t reply_queue [$];

	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	int unsigned hold_left;
	logic hold_req;
	bit failed;

	nfa_transition_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.source_state(source_state),
		.input_symbol(input_symbol),
		.target_state(target_state),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.changed(changed),
		.target_set(target_set),
		.transition_total(transition_total),
		.deterministic(deterministic)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic bit row_has_many(input logic [SET_W-1:0] row);
		return (row & (row - 1'b1)) != '0;
	endfunction

	function automatic table_reply_t apply_transaction(input logic [KIND_W-1:0] op,
			input logic [FIELD_W-1:0] src, input logic [FIELD_W-1:0] sym,
			input logic [FIELD_W-1:0] tgt);
		table_reply_t reply;
		int idx;
		logic [SET_W-1:0] prior;
		logic [SET_W-1:0] updated;
		logic [SET_W-1:0] bit_mask;
		reply = '0;
		if (src < STATE_COUNT && sym < SYMBOL_COUNT) begin
			idx = src * SYMBOL_COUNT + sym;
			prior = row_table[idx];
			updated = prior;
			if ((op == KIND_ADD || op == KIND_REMOVE) && tgt < STATE_COUNT) begin
				bit_mask = 16'd1 << tgt;
				if (op == KIND_ADD && (prior & bit_mask) == '0) begin
					updated = prior | bit_mask;
					triple_total++;
					reply.changed = 1'b1;
				end else if (op == KIND_REMOVE && (prior & bit_mask) != '0) begin
					updated = prior & ~bit_mask;
					triple_total--;
					reply.changed = 1'b1;
				end
				if (reply.changed) begin
					if (row_has_many(updated) && !row_has_many(prior))
						crowded_rows++;
					else if (row_has_many(prior) && !row_has_many(updated))
						crowded_rows--;
					row_table[idx] = updated;
				end
			end
			reply.target_set = updated;
		end
		reply.transition_total = triple_total[TOTAL_W-1:0];
		reply.deterministic = (crowded_rows == 0);
		return reply;
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] op, input logic [FIELD_W-1:0] src,
			input logic [FIELD_W-1:0] sym, input logic [FIELD_W-1:0] tgt);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		kind <= op;
		source_state <= src;
		input_symbol <= sym;
		target_state <= tgt;
		do @(posedge clk); while (in_stall !== 1'b0);
		reply_queue.push_back(apply_transaction(op, src, sym, tgt));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (reply_queue.size() != 0);
	endtask

	task automatic send_random(input int count, input int add_pct, input int remove_pct);
		logic [KIND_W-1:0] op;
		logic [FIELD_W-1:0] src;
		logic [FIELD_W-1:0] sym;
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < add_pct)
				op = KIND_ADD;
			else if (roll < add_pct + remove_pct)
				op = KIND_REMOVE;
			else if ($urandom_range(3) == 0)
				op = KIND_SPARE;
			else
				op = KIND_LOOKUP;
			// Most transactions hit a few rows so that sets fill, collide and empty again.
			if ($urandom_range(99) < 70) begin
				src = $urandom_range(1) ? 4'd3 : 4'd12;
				sym = $urandom_range(1) ? 4'd0 : 4'd9;
			end else begin
				src = FIELD_W'($urandom_range(15));
				sym = FIELD_W'($urandom_range(15));
			end
			send_item(op, src, sym, FIELD_W'($urandom_range(15)));
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	initial begin : result_checker
		table_reply_t want;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				if (reply_queue.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual %b %h %h %b",
						$time, changed, target_set, transition_total, deterministic);
					failed = 1'b1;
				end else begin
					want = reply_queue.pop_front();
					check_field("changed", want.changed, changed);
					check_field("target_set", want.target_set, target_set);
					check_field("transition_total", want.transition_total, transition_total);
					check_field("deterministic", want.deterministic, deterministic);
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
	end

	task automatic test_directed;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_item(KIND_LOOKUP, 4'd0, 4'd0, 4'd0);
		send_item(KIND_ADD, 4'd0, 4'd0, 4'd0);
		send_item(KIND_ADD, 4'd0, 4'd0, 4'd0);
		send_item(KIND_ADD, 4'd0, 4'd0, 4'd15);
		send_item(KIND_REMOVE, 4'd0, 4'd0, 4'd7);
		send_item(KIND_REMOVE, 4'd0, 4'd0, 4'd0);
		send_item(KIND_SPARE, 4'd0, 4'd0, 4'd9);
		send_item(KIND_ADD, 4'd15, 4'd15, 4'd15);
		send_item(KIND_ADD, 4'd15, 4'd15, 4'd0);
		send_item(KIND_REMOVE, 4'd15, 4'd15, 4'd15);
		send_item(KIND_REMOVE, 4'd15, 4'd15, 4'd0);
		send_item(KIND_LOOKUP, 4'd15, 4'd15, 4'd15);
		send_item(KIND_ADD, 4'd15, 4'd0, 4'd5);
		send_item(KIND_ADD, 4'd0, 4'd15, 4'd10);
		send_item(KIND_REMOVE, 4'd0, 4'd0, 4'd15);
		send_item(KIND_ADD, 4'd10, 4'd5, 4'd3);
		send_item(KIND_ADD, 4'd10, 4'd5, 4'd12);
		send_item(KIND_REMOVE, 4'd10, 4'd5, 4'd3);
		send_item(KIND_LOOKUP, 4'd10, 4'd5, 4'd15);
		send_item(KIND_SPARE, 4'd10, 4'd5, 4'd0);
		send_item(KIND_REMOVE, 4'd15, 4'd0, 4'd5);
		send_item(KIND_REMOVE, 4'd0, 4'd15, 4'd10);
		send_item(KIND_REMOVE, 4'd10, 4'd5, 4'd12);
		drain();
	endtask

	task automatic test_steady_stream;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_random(155, 55, 30);
		drain();
	endtask

	task automatic test_sender_gaps;
		sender_idle_pct = 56;
		receiver_stall_pct = 0;
		send_random(155, 40, 40);
		drain();
	endtask

	task automatic test_receiver_stalls;
		sender_idle_pct = 0;
		receiver_stall_pct = 56;
		send_random(155, 30, 55);
		drain();
	endtask

	task automatic test_mixed_idle;
		sender_idle_pct = 15;
		receiver_stall_pct = 15;
		send_random(155, 45, 40);
		drain();
	endtask

	task automatic test_backpressure;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		send_random(60, 45, 40);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_LOOKUP;
		source_state = '0;
		input_symbol = '0;
		target_state = '0;
		hold_req = 1'b0;
		hold_left = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		failed = 1'b0;
		foreach (row_table[i])
			row_table[i] = '0;
		triple_total = 0;
		crowded_rows = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_steady_stream();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idle();
		test_backpressure();
		repeat (10) @(posedge clk);
		if (!failed)
			$display("[nfa_transition_table] OK");
		else
			$display("[nfa_transition_table] ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("[nfa_transition_table] ERROR");
		$finish;
	end

endmodule
